// File: rtl/firefly_pulse_sync_step_core_macros.svh
// Assertion macros shared by the firefly pulse sync step RTL.
`ifndef FIREFLY_PULSE_SYNC_STEP_CORE_MACROS_SVH
`define FIREFLY_PULSE_SYNC_STEP_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FFPS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FFPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/ffps_pkg.sv
// Types, constants and the hue wheel function of the firefly pulse sync step block.
package ffps_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_LIGHT_THRESHOLD   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DAYLIGHT_LEVEL    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLASH_LEVEL       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEIGHBOR_KICK     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLIND_OTHER_TICKS = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLIND_SELF_TICKS  = 3'd5;

   localparam logic [8:0]  RST_LIGHT_THRESHOLD   = 9'd20;
   localparam logic [7:0]  RST_DAYLIGHT_LEVEL    = 8'd240;
   localparam logic [15:0] RST_FLASH_LEVEL       = 16'd8000;
   localparam logic [8:0]  RST_NEIGHBOR_KICK     = 9'd400;
   localparam logic [15:0] RST_BLIND_OTHER_TICKS = 16'd800;
   localparam logic [15:0] RST_BLIND_SELF_TICKS  = 16'd100;

   // Power thresholds where the per-tick step shrinks.
   localparam logic [15:0] POWER_STEP8_ABOVE = 16'd2000;
   localparam logic [15:0] POWER_STEP4_ABOVE = 16'd3000;
   localparam logic [15:0] POWER_STEP2_ABOVE = 16'd4000;
   localparam logic [15:0] POWER_STEP1_ABOVE = 16'd6000;
   localparam logic [15:0] SYNC_WINDOW_LO    = 16'd2000;
   localparam logic [15:0] SYNC_WINDOW_HI    = 16'd7000;

   localparam logic [7:0] NERV_CAP_FROM   = 8'd158;
   localparam logic [7:0] NERV_MAX        = 8'd168;
   localparam logic [7:0] NERV_RISE       = 8'd10;
   localparam logic [7:0] NERV_FALL       = 8'd5;
   localparam logic [7:0] NERV_FLASH_FALL = 8'd3;
   localparam logic [7:0] HUE_BASE        = 8'd168;
   localparam logic [7:0] HUE_SEG_LEN     = 8'd42;
   localparam logic [7:0] HUE_FULL        = 8'd252;
   localparam logic [7:0] DAYLIGHT_GREEN  = 8'd32;

   typedef struct packed {
      logic [8:0]  light_threshold;
      logic [7:0]  daylight_level;
      logic [15:0] flash_level;
      logic [8:0]  neighbor_kick;
      logic [15:0] blind_other_ticks;
      logic [15:0] blind_self_ticks;
   } cfg_type;

   typedef struct packed {
      logic       daylight_seen;
      logic       flash_now;
      logic [7:0] red_level;
      logic [7:0] green_level;
      logic [7:0] blue_level;
      logic [7:0] nervous_level;
   } rsp_beat_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef enum logic [2:0] {
      SEG_RED_GREEN_UP,
      SEG_RED_DOWN,
      SEG_BLUE_UP,
      SEG_GREEN_DOWN,
      SEG_RED_UP,
      SEG_BLUE_DOWN
   } hue_seg_type;

   // 252-step hue wheel; hues from 252 up wrap into the first segment.
   function automatic rgb_type hue_to_rgb(input logic [7:0] hue);
      hue_seg_type seg;
      logic [7:0]  base;
      logic [5:0]  frac;
      logic [7:0]  ramp;
      logic [7:0]  down;
      rgb_type     c;
      if (hue < HUE_SEG_LEN) begin
         seg = SEG_RED_GREEN_UP; base = 8'd0;
      end else if (hue < 8'(2 * HUE_SEG_LEN)) begin
         seg = SEG_RED_DOWN;     base = HUE_SEG_LEN;
      end else if (hue < 8'(3 * HUE_SEG_LEN)) begin
         seg = SEG_BLUE_UP;      base = 8'(2 * HUE_SEG_LEN);
      end else if (hue < 8'(4 * HUE_SEG_LEN)) begin
         seg = SEG_GREEN_DOWN;   base = 8'(3 * HUE_SEG_LEN);
      end else if (hue < 8'(5 * HUE_SEG_LEN)) begin
         seg = SEG_RED_UP;       base = 8'(4 * HUE_SEG_LEN);
      end else if (hue < HUE_FULL) begin
         seg = SEG_BLUE_DOWN;    base = 8'(5 * HUE_SEG_LEN);
      end else begin
         seg = SEG_RED_GREEN_UP; base = HUE_FULL;
      end
      frac = 6'(hue - base);
      ramp = 8'({2'b00, frac} * 8'd6);
      down = HUE_FULL - ramp;
      unique case (seg)
         SEG_RED_GREEN_UP: c = '{red: HUE_FULL, green: ramp,     blue: 8'd0};
         SEG_RED_DOWN:     c = '{red: down,     green: HUE_FULL, blue: 8'd0};
         SEG_BLUE_UP:      c = '{red: 8'd0,     green: HUE_FULL, blue: ramp};
         SEG_GREEN_DOWN:   c = '{red: 8'd0,     green: down,     blue: HUE_FULL};
         SEG_RED_UP:       c = '{red: ramp,     green: 8'd0,     blue: HUE_FULL};
         SEG_BLUE_DOWN:    c = '{red: HUE_FULL, green: 8'd0,     blue: down};
         default:          c = '{red: HUE_FULL, green: ramp,     blue: 8'd0};
      endcase
      return c;
   endfunction

endpackage

// File: rtl/ffps_if.sv
// Handshake interfaces for the light sample and result channels.
interface ffps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] light_sample;

   modport source (output valid, output light_sample, input ready);
   modport sink (input valid, input light_sample, output ready);
endinterface

interface ffps_rsp_if;
   logic       valid;
   logic       ready;
   logic       daylight_seen;
   logic       flash_now;
   logic [7:0] red_level;
   logic [7:0] green_level;
   logic [7:0] blue_level;
   logic [7:0] nervous_level;

   modport source (output valid, output daylight_seen, output flash_now, output red_level,
                   output green_level, output blue_level, output nervous_level, input ready);
   modport sink (input valid, input daylight_seen, input flash_now, input red_level,
                 input green_level, input blue_level, input nervous_level, output ready);
endinterface

// File: rtl/firefly_pulse_sync_step_core.sv
// Top level of the firefly pulse sync step block: input register, registers and step logic.
//
// This block is one pulse-coupled firefly oscillator. Each beat on the request channel
// carries one light sample, and each produces exactly one beat on the response channel
// with the daylight flag, the own-flash flag, the flash color and the nervousness after
// the update. An accepted sample is first held in an input register; from there, once the
// result register is free, the oscillator update (power step, neighbor-flash check with
// boost, flash compare and hue wheel) is done in one pass of logic into the result
// register, which then presents the response. While responses are taken, one sample can
// be accepted in every cycle; the sustained rate is one beat per cycle, set by that
// single update pass, which also carries the state from one sample to the
// next. The response register lets a new sample enter while a finished result still
// waits to be taken, and a stalled response backs up into the input register before the
// request channel stalls. Configuration registers are written on the csr_ port (index 0
// light threshold, 1 daylight level, 2 flash level, 3 power added on a neighbor flash,
// 4 blind ticks after a neighbor flash, 5 blind ticks after an own flash; other indexes
// are ignored) and should be written only while the block is idle.
module firefly_pulse_sync_step_core (
   input  logic                                 clock,
   input  logic                                 reset,
   ffps_req_if.sink                             req_chan,
   ffps_rsp_if.source                           rsp_chan,
   input  logic                                 csr_we,
   input  logic [ffps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ffps_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ffps_pkg::*;

   cfg_type      cfg;
   rsp_beat_type rsp_beat;
   logic         step_ready;

   // Input register holding one accepted sample until the step logic takes it.
   logic         in_valid_ff;
   logic         in_valid_in;
   logic [7:0]   sample_ff;
   logic         req_accept;

   // The slot is free when empty or when its sample moves on in this cycle.
   assign req_chan.ready = !in_valid_ff || step_ready;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign in_valid_in    = req_accept || (in_valid_ff && !step_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_ff <= req_chan.light_sample;
      end
   end

   ffps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ffps_step u_step (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .item_valid  (in_valid_ff),
      .item_sample (sample_ff),
      .item_ready  (step_ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_beat    (rsp_beat)
   );

   // Result fields go straight from the result register to the channel.
   assign rsp_chan.daylight_seen = rsp_beat.daylight_seen;
   assign rsp_chan.flash_now     = rsp_beat.flash_now;
   assign rsp_chan.red_level     = rsp_beat.red_level;
   assign rsp_chan.green_level   = rsp_beat.green_level;
   assign rsp_chan.blue_level    = rsp_beat.blue_level;
   assign rsp_chan.nervous_level = rsp_beat.nervous_level;
endmodule

// File: rtl/ffps_csr.sv
// Configuration register file of the firefly pulse sync step block.
module ffps_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [ffps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ffps_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output ffps_pkg::cfg_type                    cfg
);
   import ffps_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LIGHT_THRESHOLD:   cfg_in.light_threshold   = csr_wdata[8:0];
            CSR_DAYLIGHT_LEVEL:    cfg_in.daylight_level    = csr_wdata[7:0];
            CSR_FLASH_LEVEL:       cfg_in.flash_level       = csr_wdata;
            CSR_NEIGHBOR_KICK:     cfg_in.neighbor_kick     = csr_wdata[8:0];
            CSR_BLIND_OTHER_TICKS: cfg_in.blind_other_ticks = csr_wdata;
            CSR_BLIND_SELF_TICKS:  cfg_in.blind_self_ticks  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.light_threshold   <= RST_LIGHT_THRESHOLD;
         cfg_ff.daylight_level    <= RST_DAYLIGHT_LEVEL;
         cfg_ff.flash_level       <= RST_FLASH_LEVEL;
         cfg_ff.neighbor_kick     <= RST_NEIGHBOR_KICK;
         cfg_ff.blind_other_ticks <= RST_BLIND_OTHER_TICKS;
         cfg_ff.blind_self_ticks  <= RST_BLIND_SELF_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

// File: rtl/ffps_step.sv
// Oscillator state, per-tick update logic and result register.
`include "firefly_pulse_sync_step_core_macros.svh"
module ffps_step (
   input  logic                       clock,
   input  logic                       reset,
   input  ffps_pkg::cfg_type          cfg,
   input  logic                       item_valid,
   input  logic [7:0]                 item_sample,
   output logic                       item_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output ffps_pkg::rsp_beat_type     rsp_beat
);
   import ffps_pkg::*;

   logic [15:0]  power_ff;
   logic [15:0]  power_in;
   logic [15:0]  blind_ff;
   logic [15:0]  blind_in;
   logic [7:0]   nerv_ff;
   logic [7:0]   nerv_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_beat_type rsp_beat_ff;
   rsp_beat_type rsp_beat_in;

   logic         fire;
   logic [4:0]   step;
   logic [15:0]  power_stepped;
   logic [15:0]  power_boosted;
   logic [7:0]   nerv_mid;
   logic         day;
   logic         neighbour;
   logic         flash;
   rgb_type      colour;

   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign fire       = item_valid && item_ready;

   always_comb begin
      if (power_ff > POWER_STEP1_ABOVE) begin
         step = 5'd1;
      end else if (power_ff > POWER_STEP2_ABOVE) begin
         step = 5'd2;
      end else if (power_ff > POWER_STEP4_ABOVE) begin
         step = 5'd4;
      end else if (power_ff > POWER_STEP8_ABOVE) begin
         step = 5'd8;
      end else begin
         step = 5'd16;
      end
      power_stepped = power_ff + {11'd0, step};

      day       = (blind_ff == 16'd0) && (item_sample > cfg.daylight_level);
      neighbour = (blind_ff == 16'd0) && !day && ({1'b0, item_sample} > cfg.light_threshold);

      nerv_mid      = nerv_ff;
      power_boosted = power_stepped;
      blind_in      = blind_ff;
      if (blind_ff != 16'd0) begin
         blind_in = blind_ff - 16'd1;
      end
      if (neighbour) begin
         if (power_stepped > SYNC_WINDOW_LO && power_stepped < SYNC_WINDOW_HI) begin
            nerv_mid = (nerv_ff >= NERV_CAP_FROM) ? NERV_MAX : nerv_ff + NERV_RISE;
         end else if (nerv_ff > NERV_FALL) begin
            nerv_mid = nerv_ff - NERV_FALL;
         end
         power_boosted = power_stepped + {7'd0, cfg.neighbor_kick};
         blind_in      = cfg.blind_other_ticks;
      end

      flash    = power_boosted > cfg.flash_level;
      colour   = hue_to_rgb(HUE_BASE - nerv_mid);
      power_in = power_boosted;
      nerv_in  = nerv_mid;
      if (flash) begin
         power_in = 16'd0;
         blind_in = cfg.blind_self_ticks;
         if (nerv_mid > NERV_FLASH_FALL) begin
            nerv_in = nerv_mid - NERV_FLASH_FALL;
         end
      end

      rsp_beat_in.daylight_seen = day;
      rsp_beat_in.flash_now     = flash;
      rsp_beat_in.red_level     = flash ? colour.red : 8'd0;
      rsp_beat_in.green_level   = flash ? colour.green : (day ? DAYLIGHT_GREEN : 8'd0);
      rsp_beat_in.blue_level    = flash ? colour.blue : 8'd0;
      rsp_beat_in.nervous_level = nerv_in;

      rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_ff     <= 16'd0;
         blind_ff     <= 16'd0;
         nerv_ff      <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            power_ff <= power_in;
            blind_ff <= blind_in;
            nerv_ff  <= nerv_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_beat_ff <= rsp_beat_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

   `FFPS_ASSERT_SAME(a_nerv_range, clock, reset, 1'b1, nerv_ff <= NERV_MAX,
                     "nervousness above cap")
   `FFPS_ASSERT_NEXT(a_flash_clears_power, clock, reset, fire && flash, power_ff == 16'd0,
                     "power not cleared after flash")
   `FFPS_ASSERT_NEXT(a_flash_sets_blind, clock, reset, fire && flash,
                     blind_ff == $past(cfg.blind_self_ticks),
                     "blind count not reloaded after flash")
   `FFPS_ASSERT_SAME(a_flash_full_channel, clock, reset,
                     rsp_valid_ff && rsp_beat_ff.flash_now,
                     rsp_beat_ff.red_level == HUE_FULL || rsp_beat_ff.green_level == HUE_FULL ||
                     rsp_beat_ff.blue_level == HUE_FULL,
                     "flash colour lacks a full channel")
endmodule
